// File: src/spat_pkg.sv
// Shared types, register indexes and fixed-point helpers for the sky projection block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spat_pkg;

   typedef struct packed {
      logic signed [31:0] coord_a;
      logic signed [31:0] coord_b;
   } spat_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
   } spat_rsp_type;

   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKY_CENTER  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_XX     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_XY     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_YX     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_YY     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y    = 4'd7;

   // Rotation chain start value, 1/K in Q2.30.
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [35:0] ONE_Q30      = 36'sd1073741824;
   localparam logic [20:0]        ARCSEC_PER_TURN = 21'd1296000;

   // atan(2^-i) as a binary angle, full turn 2^32.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Q30 product rounded half up: floor((a*b + 2^29) / 2^30).
   function automatic logic signed [35:0] mul_q30(input logic signed [35:0] a,
                                                  input logic signed [35:0] b);
      logic signed [71:0] p;
      p = a * b + 72'sd536870912;
      return p[65:30];
   endfunction

endpackage

`default_nettype wire

// File: src/spat_sincos.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle in Q2.30.
// Depends on spat_pkg for the arctangent table and start constants.
`default_nettype none

module spat_sincos #(
   parameter int ITERATIONS = 24
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        angle,
   output logic signed [33:0]      cos_q,
   output logic signed [33:0]      sin_q
);
   import spat_pkg::*;

   logic signed [33:0] x_ff   [0:ITERATIONS];
   logic signed [33:0] y_ff   [0:ITERATIONS];
   logic signed [33:0] z_ff   [0:ITERATIONS];
   logic               neg_ff [0:ITERATIONS];

   logic signed [33:0] z0_in;
   logic               neg0_in;

   // Fold the angle into the right half plane; the result is negated at the end.
   always_comb begin
      z0_in   = 34'(signed'(angle));
      neg0_in = 1'b0;
      if (z0_in > QUARTER_TURN) begin
         z0_in   = z0_in - HALF_TURN;
         neg0_in = 1'b1;
      end else if (z0_in < -QUARTER_TURN) begin
         z0_in   = z0_in + HALF_TURN;
         neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= CORDIC_START;
         y_ff[0]   <= '0;
         z_ff[0]   <= z0_in;
         neg_ff[0] <= neg0_in;
         for (int i = 0; i < ITERATIONS; i++) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed({2'b00, atan_entry(5'(i))});
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed({2'b00, atan_entry(5'(i))});
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign cos_q = neg_ff[ITERATIONS] ? -x_ff[ITERATIONS] : x_ff[ITERATIONS];
   assign sin_q = neg_ff[ITERATIONS] ? -y_ff[ITERATIONS] : y_ff[ITERATIONS];

endmodule

`default_nettype wire

// File: src/spat_atan2.sv
// Pipelined vectoring-mode CORDIC giving atan2(y, x) as a binary angle.
// Depends on spat_pkg for the arctangent table and turn constants.
`default_nettype none

module spat_atan2 #(
   parameter int ITERATIONS = 24
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [35:0] y_in,
   input  wire logic signed [35:0] x_in,
   output logic signed [33:0]      angle
);
   import spat_pkg::*;

   logic signed [35:0] x_ff    [0:ITERATIONS];
   logic signed [35:0] y_ff    [0:ITERATIONS];
   logic signed [33:0] z_ff    [0:ITERATIONS];
   logic               zero_ff [0:ITERATIONS];

   logic signed [35:0] x0_in;
   logic signed [35:0] y0_in;
   logic signed [33:0] z0_in;

   // A vector in the left half plane is turned by half a turn first.
   always_comb begin
      x0_in = x_in;
      y0_in = y_in;
      z0_in = '0;
      if (x_in < 0) begin
         x0_in = -x_in;
         y0_in = -y_in;
         z0_in = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         for (int i = 0; i < ITERATIONS; i++) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed({2'b00, atan_entry(5'(i))});
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed({2'b00, atan_entry(5'(i))});
            end
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // The bearing of the null vector is defined as zero.
   assign angle = zero_ff[ITERATIONS] ? '0 : z_ff[ITERATIONS];

endmodule

`default_nettype wire

// File: src/sky_projection_affine_transform.sv
// Sky projection about a field center followed by a six-coefficient affine map.
// Depends on spat_pkg, spat_sincos and spat_atan2.
//
// The block takes one coordinate pair per item and returns one transformed pair per
// item. With projection disabled the pair is (x, y) in signed Q24.8 and goes straight
// to the affine map. With projection enabled it is (right ascension, declination) as
// 32-bit binary angles; the block forms the angular distance rho from the configured
// field center by the spherical cosine law and an arccosine, a bearing theta by atan2,
// and feeds (rho*cos(theta), rho*sin(theta)) in arcseconds, Q24.8, to the affine map.
// Outputs saturate to 32 bits. The pipeline accepts one item every clock cycle while
// the result side does not stall. Between acceptance and the result lie three CORDIC
// chains in series (sine and cosine of the inputs, the two atan2 evaluations side by
// side, sine and cosine of the bearing) and a 31-stage integer square root. When the
// result side stalls, the whole pipeline holds, so no item is lost or repeated.
// Configuration writes are taken at any time but must only be issued while no item
// is in flight.
`default_nettype none

module sky_projection_affine_transform #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire spat_pkg::spat_req_type            req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output spat_pkg::spat_rsp_type                 rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [spat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [63:0]                       csr_wdata
);
   import spat_pkg::*;

   localparam int N   = CORDIC_ITERATIONS;
   localparam int LSC = N + 1;
   localparam int LAT = N + 1;
   localparam int LSQ = 31;

   // Stage indexes: the register level at which each value is available.
   localparam int ST_IN  = 0;
   localparam int ST_SC  = ST_IN + LSC;
   localparam int ST_M1  = ST_SC + 1;
   localparam int ST_M2  = ST_SC + 2;
   localparam int ST_CL  = ST_SC + 3;
   localparam int ST_SQ  = ST_SC + 4;
   localparam int ST_V   = ST_SC + 5;
   localparam int ST_RT  = ST_V + LSQ;
   localparam int ST_AT  = ST_RT + LAT;
   localparam int ST_RH  = ST_AT + 1;
   localparam int ST_TS  = ST_RH + LSC;
   localparam int ST_PJ  = ST_TS + 1;
   localparam int ST_PR  = ST_PJ + 1;
   localparam int ST_SM  = ST_PR + 1;
   localparam int ST_OUT = ST_SM + 1;

   // ---------------------------------------------------------------------------------
   // Configuration registers. Writes are always accepted; unknown indexes are dropped.
   // ---------------------------------------------------------------------------------
   logic               proj_en_ff;
   logic [63:0]        center_ff;
   logic signed [31:0] coef_xx_ff;
   logic signed [31:0] coef_xy_ff;
   logic signed [31:0] offset_x_ff;
   logic signed [31:0] coef_yx_ff;
   logic signed [31:0] coef_yy_ff;
   logic signed [31:0] offset_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_en_ff  <= 1'b0;
         center_ff   <= '0;
         coef_xx_ff  <= 32'sd65536;
         coef_xy_ff  <= '0;
         offset_x_ff <= '0;
         coef_yx_ff  <= '0;
         coef_yy_ff  <= 32'sd65536;
         offset_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROJ_ENABLE: proj_en_ff  <= csr_wdata[0];
            CSR_SKY_CENTER:  center_ff   <= csr_wdata;
            CSR_COEF_XX:     coef_xx_ff  <= signed'(csr_wdata[31:0]);
            CSR_COEF_XY:     coef_xy_ff  <= signed'(csr_wdata[31:0]);
            CSR_OFFSET_X:    offset_x_ff <= signed'(csr_wdata[31:0]);
            CSR_COEF_YX:     coef_yx_ff  <= signed'(csr_wdata[31:0]);
            CSR_COEF_YY:     coef_yy_ff  <= signed'(csr_wdata[31:0]);
            CSR_OFFSET_Y:    offset_y_ff <= signed'(csr_wdata[31:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Pipeline control. Every stage moves together; a stalled result holds the pipe.
   // Valid bits travel alongside the data of each stage.
   // ---------------------------------------------------------------------------------
   logic adv;
   logic vld_ff [0:ST_OUT];

   assign adv       = !vld_ff[ST_OUT] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_OUT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= ST_OUT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Input stage and the first three sine/cosine chains.
   // The raw pair rides along unchanged for the case where projection is off.
   // ---------------------------------------------------------------------------------
   spat_req_type coord_ff [0:ST_TS];
   logic [31:0]  dra_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         coord_ff[0] <= req_data;
         dra_ff      <= req_data.coord_a - center_ff[63:32];
         for (int k = 1; k <= ST_TS; k++) begin
            coord_ff[k] <= coord_ff[k-1];
         end
      end
   end

   logic signed [33:0] cb, sb, cc, sc, cd, sd;

   spat_sincos #(.ITERATIONS(N)) u_sc_dec (
      .clock (clock),
      .en    (adv),
      .angle (coord_ff[0].coord_b),
      .cos_q (cb),
      .sin_q (sb)
   );

   spat_sincos #(.ITERATIONS(N)) u_sc_ctr (
      .clock (clock),
      .en    (adv),
      .angle (center_ff[31:0]),
      .cos_q (cc),
      .sin_q (sc)
   );

   spat_sincos #(.ITERATIONS(N)) u_sc_dra (
      .clock (clock),
      .en    (adv),
      .angle (dra_ff),
      .cos_q (cd),
      .sin_q (sd)
   );

   // ---------------------------------------------------------------------------------
   // Cosine law and the numerator and denominator of the bearing.
   // ---------------------------------------------------------------------------------
   logic signed [35:0] t1_ff, t2_ff, t3_ff;
   logic signed [33:0] cd1_ff, cc1_ff, sb1_ff, sc1_ff;
   logic signed [35:0] craw_ff, xd2_ff;
   logic signed [33:0] sb2_ff, sc2_ff;
   logic signed [31:0] c3_ff;
   logic signed [35:0] xd3_ff;
   logic signed [33:0] sb3_ff, sc3_ff;
   logic [60:0]        csq4_ff;
   logic signed [35:0] pc4_ff, xd4_ff;
   logic signed [31:0] c4_ff;
   logic signed [33:0] sb4_ff;
   logic signed [31:0] c_clamp_in;
   logic signed [63:0] csq_full;

   // The cosine sum can overshoot unity by a few units in the last place.
   always_comb begin
      if (craw_ff > ONE_Q30) begin
         c_clamp_in = 32'(ONE_Q30);
      end else if (craw_ff < -ONE_Q30) begin
         c_clamp_in = 32'(-ONE_Q30);
      end else begin
         c_clamp_in = 32'(craw_ff);
      end
      csq_full = c3_ff * c3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= mul_q30(36'(cb), 36'(cc));
         t2_ff   <= mul_q30(36'(sb), 36'(sc));
         t3_ff   <= mul_q30(36'(cb), 36'(sd));
         cd1_ff  <= cd;
         cc1_ff  <= cc;
         sb1_ff  <= sb;
         sc1_ff  <= sc;

         craw_ff <= mul_q30(t1_ff, 36'(cd1_ff)) + t2_ff;
         xd2_ff  <= mul_q30(t3_ff, 36'(cc1_ff));
         sb2_ff  <= sb1_ff;
         sc2_ff  <= sc1_ff;

         c3_ff   <= c_clamp_in;
         xd3_ff  <= xd2_ff;
         sb3_ff  <= sb2_ff;
         sc3_ff  <= sc2_ff;

         csq4_ff <= csq_full[60:0];
         pc4_ff  <= mul_q30(36'(c3_ff), 36'(sc3_ff));
         c4_ff   <= c3_ff;
         xd4_ff  <= xd3_ff;
         sb4_ff  <= sb3_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Integer square root of 1 - c^2 in Q60, one result bit per stage.
   // ---------------------------------------------------------------------------------
   logic [60:0]        sq_v_ff  [0:LSQ];
   logic [60:0]        sq_r_ff  [0:LSQ];
   logic signed [31:0] c_d_ff   [0:LSQ];
   logic signed [35:0] yn_d_ff  [0:LSQ];
   logic signed [35:0] xd_d_ff  [0:LSQ];
   logic [60:0]        sq_vn_in [0:LSQ-1];
   logic [60:0]        sq_rn_in [0:LSQ-1];
   logic [61:0]        sq_try   [0:LSQ-1];
   logic [60:0]        sq_bit   [0:LSQ-1];

   always_comb begin
      for (int j = 0; j < LSQ; j++) begin
         sq_bit[j] = 61'(1) << (2 * (LSQ - 1 - j));
         sq_try[j] = {1'b0, sq_r_ff[j]} + {1'b0, sq_bit[j]};
         if ({1'b0, sq_v_ff[j]} >= sq_try[j]) begin
            sq_vn_in[j] = sq_v_ff[j] - sq_try[j][60:0];
            sq_rn_in[j] = (sq_r_ff[j] >> 1) + sq_bit[j];
         end else begin
            sq_vn_in[j] = sq_v_ff[j];
            sq_rn_in[j] = sq_r_ff[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_v_ff[0] <= (61'(1) << 60) - csq4_ff;
         sq_r_ff[0] <= '0;
         c_d_ff[0]  <= c4_ff;
         yn_d_ff[0] <= 36'(sb4_ff) - pc4_ff;
         xd_d_ff[0] <= xd4_ff;
         for (int j = 0; j < LSQ; j++) begin
            sq_v_ff[j+1] <= sq_vn_in[j];
            sq_r_ff[j+1] <= sq_rn_in[j];
            c_d_ff[j+1]  <= c_d_ff[j];
            yn_d_ff[j+1] <= yn_d_ff[j];
            xd_d_ff[j+1] <= xd_d_ff[j];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Arccosine and bearing, evaluated side by side.
   // ---------------------------------------------------------------------------------
   logic signed [33:0] z_rho, z_theta;

   spat_atan2 #(.ITERATIONS(N)) u_at_rho (
      .clock (clock),
      .en    (adv),
      .y_in  ($signed({5'b00000, sq_r_ff[LSQ][30:0]})),
      .x_in  (36'(c_d_ff[LSQ])),
      .angle (z_rho)
   );

   spat_atan2 #(.ITERATIONS(N)) u_at_theta (
      .clock (clock),
      .en    (adv),
      .y_in  (yn_d_ff[LSQ]),
      .x_in  (xd_d_ff[LSQ]),
      .angle (z_theta)
   );

   // ---------------------------------------------------------------------------------
   // Distance clamp, conversion to arcseconds and sine/cosine of the bearing.
   // The arcsecond distance is delayed to line up with the bearing chain's output.
   // ---------------------------------------------------------------------------------
   logic [31:0]        rho_ff;
   logic [31:0]        theta_ff;
   logic [31:0]        rho_clamp_in;
   logic [52:0]        rq_prod;
   logic [28:0]        rq_ff [0:N];
   logic signed [33:0] ct, st;

   always_comb begin
      if (z_rho < 0) begin
         rho_clamp_in = '0;
      end else if (z_rho > HALF_TURN) begin
         rho_clamp_in = 32'(HALF_TURN);
      end else begin
         rho_clamp_in = 32'(z_rho);
      end
      rq_prod = 53'(rho_ff) * 53'(ARCSEC_PER_TURN) + (53'(1) << 23);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rho_ff   <= rho_clamp_in;
         theta_ff <= z_theta[31:0];
         rq_ff[0] <= rq_prod[52:24];
         for (int k = 1; k <= N; k++) begin
            rq_ff[k] <= rq_ff[k-1];
         end
      end
   end

   spat_sincos #(.ITERATIONS(N)) u_sc_theta (
      .clock (clock),
      .en    (adv),
      .angle (theta_ff),
      .cos_q (ct),
      .sin_q (st)
   );

   // ---------------------------------------------------------------------------------
   // Projected pair or raw pair, then the affine map with rounding and saturation.
   // ---------------------------------------------------------------------------------
   logic signed [31:0] px_ff, py_ff;
   logic signed [35:0] px_proj, py_proj;
   logic signed [63:0] p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic signed [48:0] sx_ff, sy_ff;
   logic signed [64:0] sum_x, sum_y;
   logic signed [49:0] vx, vy;
   spat_rsp_type       rsp_ff;
   spat_rsp_type       rsp_in;

   always_comb begin
      px_proj = mul_q30(36'(rq_ff[N]), 36'(ct));
      py_proj = mul_q30(36'(rq_ff[N]), 36'(st));
      sum_x   = 65'(p_xx_ff) + 65'(p_xy_ff) + 65'sd32768;
      sum_y   = 65'(p_yx_ff) + 65'(p_yy_ff) + 65'sd32768;
      vx      = 50'(sx_ff) + 50'(offset_x_ff);
      vy      = 50'(sy_ff) + 50'(offset_y_ff);
      if (vx > 50'sd2147483647) begin
         rsp_in.out_x = 32'sh7FFFFFFF;
      end else if (vx < -50'sd2147483648) begin
         rsp_in.out_x = 32'sh80000000;
      end else begin
         rsp_in.out_x = 32'(vx);
      end
      if (vy > 50'sd2147483647) begin
         rsp_in.out_y = 32'sh7FFFFFFF;
      end else if (vy < -50'sd2147483648) begin
         rsp_in.out_y = 32'sh80000000;
      end else begin
         rsp_in.out_y = 32'(vy);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (proj_en_ff) begin
            px_ff <= 32'(px_proj);
            py_ff <= 32'(py_proj);
         end else begin
            px_ff <= coord_ff[ST_TS].coord_a;
            py_ff <= coord_ff[ST_TS].coord_b;
         end
         p_xx_ff <= px_ff * coef_xx_ff;
         p_xy_ff <= py_ff * coef_xy_ff;
         p_yx_ff <= px_ff * coef_yx_ff;
         p_yy_ff <= py_ff * coef_yy_ff;
         sx_ff   <= 49'(sum_x >>> 16);
         sy_ff   <= 49'(sum_y >>> 16);
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------------------------------------------------------------------------
   // Checks on the pipeline's own invariants.
   // ---------------------------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT-1] && adv |=> rsp_valid)
      else $error("item in the last stage did not reach the output");

   assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[ST_V] == $past(vld_ff[ST_V]) && vld_ff[ST_RH] == $past(vld_ff[ST_RH]))
      else $error("pipeline moved while the output was stalled");

   assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_CL] |-> (c3_ff <= 32'sd1073741824) && (c3_ff >= -32'sd1073741824))
      else $error("clamped cosine out of range");

   assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RT] |-> sq_r_ff[LSQ] <= (61'(1) << 30))
      else $error("square root exceeds unity");

   assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RH] |-> rho_ff <= 32'h80000000)
      else $error("angular distance beyond half a turn");

endmodule

`default_nettype wire
